/* design/time_slot_task_dispatcher_assert.svh */
// Assertion macros for the time slot task dispatcher checker.
// Depends on signals named clk and rst in the module that uses them.
`ifndef TIME_SLOT_TASK_DISPATCHER_ASSERT_SVH
`define TIME_SLOT_TASK_DISPATCHER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The same check, also evaluated while reset is asserted.
`define TSD_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tsd_pkg.sv */
// Shared types, constants and the slot decoder of the time slot task dispatcher.
// Used by the top level; depends on nothing else.
package tsd_pkg;

  localparam int TASK_COUNT_DEF = 21;
  localparam int DIVIDER_COUNT  = 5;
  localparam int DIV_W          = 6;
  localparam int SLOT_W         = 6;
  localparam int TASK_W         = 5;
  localparam int DIV_IDX_W      = $clog2(DIVIDER_COUNT);
  localparam int CFG_INDEX_W    = $clog2(DIVIDER_COUNT);

  // Item kinds carried in the input tuser field.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_TASK_DIV    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_STORE_TASK_DIV    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_REPORT_DIV   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SYSTEM_REPORT_DIV = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_DIV       = CFG_INDEX_W'(4);

  localparam logic [DIV_W-1:0] DIVIDER_RESET [DIVIDER_COUNT] =
    '{6'd10, 6'd40, 6'd2, 6'd2, 6'd6};
  localparam logic [TASK_W-1:0] DIVIDED_TASK [DIVIDER_COUNT] =
    '{5'd11, 5'd15, 5'd17, 5'd18, 5'd19};

  typedef enum logic [1:0] {
    MAP_NONE    = 2'd0,
    MAP_DIRECT  = 2'd1,
    MAP_DIVIDED = 2'd2
  } map_kind_t;

  typedef struct packed {
    map_kind_t              kind;
    logic [TASK_W-1:0]      task_id;
    logic [DIV_IDX_W-1:0]   div_sel;
  } slot_map_t;

  function automatic slot_map_t direct_map(input logic [TASK_W-1:0] id);
    slot_map_t m;
    m.kind    = MAP_DIRECT;
    m.task_id = id;
    m.div_sel = '0;
    return m;
  endfunction

  function automatic slot_map_t divided_map(input logic [DIV_IDX_W-1:0] sel);
    slot_map_t m;
    m.kind    = MAP_DIVIDED;
    m.task_id = '0;
    m.div_sel = sel;
    return m;
  endfunction

  // Fixed slot-to-task table of one 50-slot frame.
  function automatic slot_map_t slot_map(input logic [SLOT_W-1:0] slot);
    slot_map_t m;
    m.kind    = MAP_NONE;
    m.task_id = '0;
    m.div_sel = '0;
    unique case (slot) inside
      6'd1:                          m = direct_map(5'd0);
      6'd3:                          m = direct_map(5'd1);
      6'd5, 6'd15, 6'd25, 6'd35, 6'd45: m = direct_map(5'd2);
      6'd7:                          m = direct_map(5'd3);
      6'd9:                          m = direct_map(5'd4);
      6'd11:                         m = direct_map(5'd5);
      6'd13:                         m = direct_map(5'd6);
      6'd17:                         m = direct_map(5'd7);
      6'd21:                         m = direct_map(5'd8);
      6'd23:                         m = direct_map(5'd9);
      6'd27:                         m = direct_map(5'd10);
      6'd29:                         m = divided_map(REG_CLOCK_TASK_DIV);
      6'd31:                         m = direct_map(5'd12);
      6'd33:                         m = direct_map(5'd13);
      6'd37:                         m = direct_map(5'd14);
      6'd39:                         m = direct_map(5'd16);
      6'd40:                         m = direct_map(5'd20);
      6'd41:                         m = divided_map(REG_STORE_TASK_DIV);
      6'd43:                         m = divided_map(REG_CELL_REPORT_DIV);
      6'd47:                         m = divided_map(REG_SYSTEM_REPORT_DIV);
      6'd49:                         m = divided_map(REG_DISPLAY_DIV);
      default:                       m.kind = MAP_NONE;
    endcase
    return m;
  endfunction

endpackage

/* design/time_slot_task_dispatcher.sv */
// Time slot task dispatcher: tick items set task pending flags, poll items drain them.
// Depends on tsd_pkg for the slot table, divider resets and item codes.
//
// A tick item is accepted in the idle state; then, in the tick state, the single
// divider unit (one count compare and one increment) updates the slot's counter and
// the pending flags. A poll item is accepted in the idle state; in the poll state the
// lowest-first priority encoder then moves one task per cycle into the output register
// whenever the output is free; a stalled output holds the poll. The input is not ready
// while an item is being worked on. A poll with nothing pending returns to idle and
// emits nothing.
module time_slot_task_dispatcher #(
  parameter int TASK_COUNT = tsd_pkg::TASK_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [5:0] slot
  input  logic [0:0]                         s_axis_tuser,  // [0] action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [4:0] task_index
  output logic                               m_axis_tlast,
  input  logic                               cfg_we,
  input  logic [tsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tsd_pkg::DIV_W-1:0]          cfg_data
);
  import tsd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_POLL = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [SLOT_W-1:0]      slot_q;
  logic [TASK_COUNT-1:0]  pending, pending_next;
  logic [DIV_W-1:0]       dividers [DIVIDER_COUNT];
  logic [DIV_W-1:0]       divider_count [DIVIDER_COUNT];

  logic                   out_valid;
  logic [TASK_W-1:0]      out_task;
  logic                   out_last;

  // Divider unit.
  slot_map_t              map;
  logic [DIV_W-1:0]       cnt;
  logic [DIV_W-1:0]       div_val;
  logic                   fire;
  logic [TASK_W-1:0]      set_id;
  logic                   set_en;

  // Priority encoder.
  logic [TASK_COUNT-1:0]  lowest;
  logic [TASK_COUNT-1:0]  remaining;
  logic [TASK_W-1:0]      enc;
  logic                   out_free;
  logic                   emit;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8 - TASK_W){1'b0}}, out_task};
  assign m_axis_tlast  = out_last;

  assign map     = slot_map(slot_q);
  assign cnt     = divider_count[map.div_sel];
  assign div_val = dividers[map.div_sel];
  assign fire    = (cnt == '0) || (cnt >= div_val);
  assign set_id  = (map.kind == MAP_DIVIDED) ? DIVIDED_TASK[map.div_sel] : map.task_id;
  assign set_en  = (state == ST_TICK) &&
                   ((map.kind == MAP_DIRECT) || ((map.kind == MAP_DIVIDED) && fire));

  assign lowest    = pending & (~pending + TASK_COUNT'(1));
  assign remaining = pending & (pending - TASK_COUNT'(1));

  always_comb begin
    enc = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      if (lowest[i]) begin
        enc = enc | TASK_W'(i);
      end
    end
  end

  assign out_free = !out_valid || m_axis_tready;
  assign emit     = (state == ST_POLL) && (pending != '0) && out_free;

  always_comb begin
    state_next   = state;
    pending_next = pending;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser[0] == ACT_POLL) ? ST_POLL : ST_TICK;
        end
      end
      ST_TICK: begin
        if (set_en) begin
          pending_next = pending | (TASK_COUNT'(1) << set_id);
        end
        state_next = ST_IDLE;
      end
      ST_POLL: begin
        if (pending == '0) begin
          state_next = ST_IDLE;
        end else if (emit) begin
          pending_next = remaining;
          if (remaining == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < DIVIDER_COUNT; i++) begin
        dividers[i]      <= DIVIDER_RESET[i];
        divider_count[i] <= '0;
      end
    end else begin
      state   <= state_next;
      pending <= pending_next;

      if (cfg_we && (cfg_index <= REG_DISPLAY_DIV)) begin
        dividers[cfg_index] <= cfg_data;
      end

      if ((state == ST_TICK) && (map.kind == MAP_DIVIDED)) begin
        divider_count[map.div_sel] <= fire ? DIV_W'(1) : cnt + DIV_W'(1);
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      slot_q <= s_axis_tdata[SLOT_W-1:0];
    end
    if (emit) begin
      out_task <= enc;
      out_last <= (remaining == '0);
    end
  end

endmodule

/* design/tsd_checker.sv */
// Port-level checker for the time slot task dispatcher, bound to the top level.
// Depends on tsd_pkg and the assertion macros in time_slot_task_dispatcher_assert.svh.
`include "time_slot_task_dispatcher_assert.svh"

module tsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [0:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import tsd_pkg::*;

  // A stalled result keeps its payload.
  `TSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Every accepted item makes the input busy, since the block leaves the idle state to work on it.
  `TSD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "input ready right after an accepted item")

  // A tick never produces a result: one accepted while the output is empty leaves it empty.
  `TSD_ASSERT_NEXT(a_tick_silent,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_TICK) && !m_axis_tvalid,
    !m_axis_tvalid, "tick produced a result")

  // A result that is not the last of its poll is followed at once by the next one.
  `TSD_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid, "poll run broke before its last item")

  // Reset empties the output register.
  `TSD_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid, "result valid after reset")

endmodule

bind time_slot_task_dispatcher tsd_checker u_tsd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* sim/time_slot_task_dispatcher_tb.sv */
// Self-checking testbench for the time slot task dispatcher.
// Needs tsd_pkg and time_slot_task_dispatcher; drives both stream sides and the register port.
`timescale 1ns / 100ps

module time_slot_task_dispatcher_tb;
  import tsd_pkg::*;

  localparam int NTASK      = TASK_COUNT_DEF;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_MAX  = 20000;
  localparam int SETTLE     = 8;
  localparam int PHASES     = 7;
  localparam int PHASE_LEN  = 40;
  localparam int MAX_REPORT = 10;

  localparam logic [CFG_INDEX_W-1:0] DIV_REGS [DIVIDER_COUNT] = '{
    REG_CLOCK_TASK_DIV, REG_STORE_TASK_DIV, REG_CELL_REPORT_DIV,
    REG_SYSTEM_REPORT_DIV, REG_DISPLAY_DIV};
  localparam logic [SLOT_W-1:0] DIVIDED_SLOTS [DIVIDER_COUNT] = '{
    6'd29, 6'd41, 6'd43, 6'd47, 6'd49};
  localparam logic [TASK_W-1:0] DIV_TASK [DIVIDER_COUNT] = '{
    5'd11, 5'd15, 5'd17, 5'd18, 5'd19};

  typedef struct packed {
    logic              act;
    logic [SLOT_W-1:0] slot;
    logic              typed;
    logic [NTASK-1:0]  mask;
  } step_row_t;

  // Rows with typed set carry the tasks their poll must drain, lowest first.
  localparam int DIRECTED_LEN = 25;
  localparam step_row_t DIRECTED [DIRECTED_LEN] = '{
    '{ACT_POLL, 6'd0,  1'b1, 21'h000000},
    '{ACT_TICK, 6'd0,  1'b0, 21'h0},
    '{ACT_TICK, 6'd63, 1'b0, 21'h0},
    '{ACT_TICK, 6'd50, 1'b0, 21'h0},
    '{ACT_TICK, 6'd19, 1'b0, 21'h0},
    '{ACT_TICK, 6'd2,  1'b0, 21'h0},
    '{ACT_POLL, 6'd63, 1'b1, 21'h000000},
    '{ACT_TICK, 6'd1,  1'b0, 21'h0},
    '{ACT_POLL, 6'd42, 1'b1, 21'h000001},
    '{ACT_TICK, 6'd40, 1'b0, 21'h0},
    '{ACT_TICK, 6'd5,  1'b0, 21'h0},
    '{ACT_TICK, 6'd45, 1'b0, 21'h0},
    '{ACT_POLL, 6'd21, 1'b1, 21'h100004},
    '{ACT_TICK, 6'd29, 1'b0, 21'h0},
    '{ACT_TICK, 6'd29, 1'b0, 21'h0},
    '{ACT_TICK, 6'd41, 1'b0, 21'h0},
    '{ACT_TICK, 6'd43, 1'b0, 21'h0},
    '{ACT_TICK, 6'd43, 1'b0, 21'h0},
    '{ACT_TICK, 6'd43, 1'b0, 21'h0},
    '{ACT_TICK, 6'd47, 1'b0, 21'h0},
    '{ACT_TICK, 6'd49, 1'b0, 21'h0},
    '{ACT_POLL, 6'd0,  1'b1, 21'h0E8800},
    '{ACT_TICK, 6'd49, 1'b0, 21'h0},
    '{ACT_TICK, 6'd29, 1'b0, 21'h0},
    '{ACT_POLL, 6'd0,  1'b1, 21'h000000}
  };

  typedef struct packed {
    logic [TASK_W-1:0] idx;
    logic              last;
  } dispatch_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;  // [5:0] slot
  logic [0:0]             s_axis_tuser = '0;  // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;       // [4:0] task_index
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DIV_W-1:0]       cfg_data = '0;

  // Predictor state.
  logic [NTASK-1:0]  pending_tasks;
  logic [DIV_W-1:0]  div_count [DIVIDER_COUNT];
  logic [DIV_W-1:0]  div_limit [DIVIDER_COUNT];
  dispatch_t         dispatch_q[$];

  int unsigned error_count = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned long_hold_req = 0;
  int unsigned long_hold_done;
  int unsigned rx_hold;
  logic [SLOT_W-1:0] frame_slot = '0;

  time_slot_task_dispatcher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORT) $display("%s", msg);
  endfunction

  // Returns the direct task of a slot in tsk, or the divider it runs through in sel.
  function automatic void decode_slot(input logic [SLOT_W-1:0] s, output int tsk,
                                      output int sel);
    tsk = -1;
    sel = -1;
    case (s)
      6'd1:  tsk = 0;
      6'd3:  tsk = 1;
      6'd5, 6'd15, 6'd25, 6'd35, 6'd45: tsk = 2;
      6'd7:  tsk = 3;
      6'd9:  tsk = 4;
      6'd11: tsk = 5;
      6'd13: tsk = 6;
      6'd17: tsk = 7;
      6'd21: tsk = 8;
      6'd23: tsk = 9;
      6'd27: tsk = 10;
      6'd31: tsk = 12;
      6'd33: tsk = 13;
      6'd37: tsk = 14;
      6'd39: tsk = 16;
      6'd40: tsk = 20;
      6'd29: sel = 0;
      6'd41: sel = 1;
      6'd43: sel = 2;
      6'd47: sel = 3;
      6'd49: sel = 4;
      default: ;
    endcase
  endfunction

  function automatic void reset_predictor();
    int i;
    pending_tasks = '0;
    for (i = 0; i < DIVIDER_COUNT; i++) begin
      div_count[i] = '0;
      div_limit[i] = DIVIDER_RESET[i];
    end
  endfunction

  // Updates the pending flags for one item and returns the set of tasks a poll drains.
  function automatic logic [NTASK-1:0] predict_item(input logic act,
                                                    input logic [SLOT_W-1:0] slot);
    int tsk;
    int sel;
    logic [NTASK-1:0] drained;
    drained = '0;
    if (act == ACT_POLL) begin
      drained = pending_tasks;
      pending_tasks = '0;
    end else begin
      decode_slot(slot, tsk, sel);
      if (tsk >= 0) begin
        pending_tasks[tsk] = 1'b1;
      end else if (sel >= 0) begin
        // A zero count is the first occurrence; a count at or past the divider fires too.
        if (div_count[sel] == '0 || div_count[sel] >= div_limit[sel]) begin
          pending_tasks[DIV_TASK[sel]] = 1'b1;
          div_count[sel] = 6'd1;
        end else begin
          div_count[sel] = div_count[sel] + 6'd1;
        end
      end
    end
    return drained;
  endfunction

  function automatic void queue_dispatches(input logic [NTASK-1:0] mask);
    int t;
    logic [NTASK-1:0] left;
    left = mask;
    for (t = 0; t < NTASK; t++) begin
      if (left[t]) begin
        left[t] = 1'b0;
        dispatch_q.push_back('{idx: TASK_W'(t), last: (left == '0)});
      end
    end
  endfunction

  function automatic void check_dispatch();
    dispatch_t want;
    if (dispatch_q.size() == 0) begin
      flag_error($sformatf("unexpected dispatch: data 0x%02h last %0b",
                           m_axis_tdata, m_axis_tlast));
    end else begin
      want = dispatch_q.pop_front();
      if (m_axis_tdata != 8'(want.idx) || m_axis_tlast != want.last)
        flag_error($sformatf("dispatch mismatch: expected task %0d last %0b, got data 0x%02h last %0b",
                             want.idx, want.last, m_axis_tdata, m_axis_tlast));
    end
  endfunction

  // Result side: checks every item taken and stalls at random or on request.
  always @(posedge clk) begin : result_sink
    int unsigned gap;
    if (rst) begin
      m_axis_tready  <= 1'b0;
      rx_hold        <= 0;
      long_hold_done <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_dispatch();
      if (long_hold_req != long_hold_done) begin
        m_axis_tready  <= 1'b0;
        rx_hold        <= LONG_HOLD;
        long_hold_done <= long_hold_done + 1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        gap = rx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          rx_hold       <= gap;
        end
      end else if (!m_axis_tready) begin
        if (rx_hold == 0) m_axis_tready <= 1'b1;
        else rx_hold <= rx_hold - 1;
      end
    end
  end

  task automatic send_item(input logic act, input logic [SLOT_W-1:0] slot, input bit typed,
                           input logic [NTASK-1:0] typed_mask);
    int unsigned gap;
    logic [NTASK-1:0] drained;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, slot};
    do @(posedge clk); while (!s_axis_tready);
    drained = predict_item(act, slot);
    queue_dispatches(typed ? typed_mask : drained);
  endtask

  // Mostly ticks on divided slots and on slots walked in frame order, some polls and noise.
  task automatic send_random_item();
    int unsigned r;
    logic [SLOT_W-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_item(ACT_POLL, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
    end else if (r < 55) begin
      send_item(ACT_TICK, DIVIDED_SLOTS[$urandom_range(0, DIVIDER_COUNT - 1)], 1'b0, '0);
    end else if (r < 90) begin
      s = frame_slot;
      frame_slot = (frame_slot == 6'd49) ? 6'd0 : frame_slot + 6'd1;
      send_item(ACT_TICK, s, 1'b0, '0);
    end else begin
      send_item(ACT_TICK, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    int unsigned n;
    n = 0;
    while (dispatch_q.size() != 0 && n < DRAIN_MAX) begin
      @(posedge clk);
      n++;
    end
    if (dispatch_q.size() != 0) begin
      flag_error($sformatf("%0d dispatches never arrived", dispatch_q.size()));
      dispatch_q.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_dividers(input logic [DIV_W-1:0] vals [DIVIDER_COUNT], input bit stray);
    int i;
    for (i = 0; i < DIVIDER_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= DIV_REGS[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      div_limit[i] = vals[i];
    end
    // Indexes past the last divider must be ignored.
    if (stray) begin
      cfg_index <= REG_DISPLAY_DIV + CFG_INDEX_W'($urandom_range(1, 3));
      cfg_data  <= DIV_W'($urandom_range(0, 63));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int i;
    int p;
    int k;
    logic [DIV_W-1:0] vals [DIVIDER_COUNT];
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    rx_idle_on <= 1'b1;
    tx_idle_on = 1'b1;
    @(posedge clk);

    for (i = 0; i < DIRECTED_LEN; i++)
      send_item(DIRECTED[i].act, DIRECTED[i].slot, DIRECTED[i].typed, DIRECTED[i].mask);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      for (k = 0; k < DIVIDER_COUNT; k++) begin
        case (p)
          0: vals[k] = 6'd63;
          1: vals[k] = 6'd1;
          2: vals[k] = 6'd0;
          3: vals[k] = DIV_W'($urandom_range(1, 63));
          4: vals[k] = DIV_W'($urandom_range(0, 63));
          5: vals[k] = DIVIDER_RESET[k];
          default: vals[k] = DIV_W'($urandom_range(1, 4));
        endcase
      end
      load_dividers(vals, p >= 3);
      tx_idle_on = (p == 3) || (p != 1 && $urandom_range(0, 3) != 0);
      rx_idle_on <= (p == 3) || (p != 1 && $urandom_range(0, 3) != 0);

      // With every divider at one, a whole frame followed by a poll drains all tasks.
      if (p == 1) begin
        for (k = 0; k < 50; k++) send_item(ACT_TICK, SLOT_W'(k), 1'b0, '0);
        send_item(ACT_POLL, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
      end
      if (p == 4) long_hold_req <= long_hold_req + 1;

      repeat (PHASE_LEN) send_random_item();
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/tsd_pkg.sv
design/time_slot_task_dispatcher.sv
design/tsd_checker.sv
sim/time_slot_task_dispatcher_tb.sv
